// ----- rtl/sps_pkg.sv -----
// Stepper phase sequencer package: codes, phase tables and result type.
// No dependencies; imported by the response interface and the top level.
package sps_pkg;

   // Number of motors served and reset value of the phase hold ticks
   localparam int MOTOR_COUNT = 4;
   localparam logic [15:0] HOLD_RESET = 16'd2;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_MOVE = 2'd1,
      FUNC_STOP = 2'd2
   } func_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_BAD_ARG = 2'd2,
      STATUS_BUSY    = 2'd3
   } status_type;

   // Direction and step mode codes
   localparam logic [1:0] DIR_CW    = 2'd0;
   localparam logic [1:0] DIR_CCW   = 2'd1;
   localparam logic [1:0] MODE_FULL = 2'd0;
   localparam logic [1:0] MODE_HALF = 2'd1;

   // Last phase index of a full and a half step cycle
   localparam logic [2:0] LAST_FULL = 3'd3;
   localparam logic [2:0] LAST_HALF = 3'd7;

   // Coil patterns, bit3 orange .. bit0 blue; index [reverse][phase]
   localparam logic [3:0] FULL_TAB [2][4] = '{
      '{4'h8, 4'h4, 4'h2, 4'h1},
      '{4'h1, 4'h2, 4'h4, 4'h8}
   };
   localparam logic [3:0] HALF_TAB [2][8] = '{
      '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9},
      '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8}
   };

   // One response item
   typedef struct packed {
      logic [3:0] drive_motor;
      logic [3:0] coil_pattern;
      logic       pattern_valid;
      status_type status;
      logic       busy_res;
      logic       move_done;
   } rsp_type;

   // Look up the coil pattern for a phase
   function automatic logic [3:0] phase_pattern(input logic half, input logic rev,
                                                input logic [2:0] phase);
      logic [3:0] pat;
      if (half) begin
         pat = HALF_TAB[rev][phase];
      end else begin
         pat = FULL_TAB[rev][phase[1:0]];
      end
      return pat;
   endfunction

endpackage

// ----- rtl/sps_if.sv -----
// Channel interfaces of the stepper phase sequencer: request, response, CSR write.
// Depends on sps_pkg for the status type.
interface sps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [3:0]  motor_index;
   logic [1:0]  direction;
   logic [1:0]  step_mode;
   logic [15:0] step_count;

   modport source (output valid, func, motor_index, direction, step_mode, step_count,
                   input ready);
   modport sink   (input valid, func, motor_index, direction, step_mode, step_count,
                   output ready);
endinterface

interface sps_rsp_if;
   import sps_pkg::*;
   logic       valid;
   logic       ready;
   logic [3:0] drive_motor;
   logic [3:0] coil_pattern;
   logic       pattern_valid;
   status_type status;
   logic       busy_res;
   logic       move_done;

   modport source (output valid, drive_motor, coil_pattern, pattern_valid, status,
                   busy_res, move_done, input ready);
   modport sink   (input valid, drive_motor, coil_pattern, pattern_valid, status,
                   busy_res, move_done, output ready);
endinterface

interface sps_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/stepper_phase_sequencer_top.sv -----
// Stepper phase sequencer top level: move/stop/tick handling and response register.
// Depends on sps_pkg and the channel interfaces in sps_if.sv.

// Drives the four coils of one of MOTOR_COUNT unipolar steppers. Each request
// (tick, move or stop) yields exactly one response, registered in the cycle after
// the request is taken; a request can be taken every cycle, and req.ready stays
// high while the response register is empty or being drained. Move and stop
// checks, the hold counter and the phase table lookup are all combinational.
// Only one move plays at a time; each phase is held phase_hold_ticks
// ticks (zero acts as one), written through the CSR port, which is always ready.
module stepper_phase_sequencer_top
   import sps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sps_req_if.sink       req_ch,
   sps_rsp_if.source     rsp_ch,
   sps_csr_if.sink       csr_ch
);

   // Sequencer state
   logic        running_ff, running_in;
   logic [3:0]  active_motor_ff, active_motor_in;
   logic [15:0] steps_left_ff, steps_left_in;
   logic [2:0]  phase_ff, phase_in;
   logic        reverse_ff, reverse_in;
   logic        half_ff, half_in;
   logic [15:0] hold_cnt_ff, hold_cnt_in;
   logic [15:0] hold_ticks_ff;

   // Response register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        req_take;
   logic        idx_ok;
   logic        args_ok;
   logic [15:0] hold_eff;
   logic [15:0] cnt_inc;
   logic [15:0] steps_dec;
   logic [2:0]  last_phase;

   // Take a request when the response slot is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign idx_ok     = {1'b0, req_ch.motor_index} < 5'(MOTOR_COUNT);
   assign args_ok    = (req_ch.direction == DIR_CW || req_ch.direction == DIR_CCW) &&
                       (req_ch.step_mode == MODE_FULL || req_ch.step_mode == MODE_HALF);
   assign hold_eff   = (hold_ticks_ff == 16'd0) ? 16'd1 : hold_ticks_ff;
   assign cnt_inc    = hold_cnt_ff + 16'd1;
   assign steps_dec  = steps_left_ff - 16'd1;
   assign last_phase = half_ff ? LAST_HALF : LAST_FULL;

   // Decode the request and advance the sequencer
   always_comb begin
      running_in      = running_ff;
      active_motor_in = active_motor_ff;
      steps_left_in   = steps_left_ff;
      phase_in        = phase_ff;
      reverse_in      = reverse_ff;
      half_in         = half_ff;
      hold_cnt_in     = hold_cnt_ff;
      rsp_in          = '0;
      rsp_in.status   = STATUS_OK;

      case (func_type'(req_ch.func))
         FUNC_MOVE: begin
            if (!idx_ok) begin
               rsp_in.status = STATUS_RANGE;
            end else if (!args_ok) begin
               rsp_in.status = STATUS_BAD_ARG;
            end else if (running_ff) begin
               rsp_in.status = STATUS_BUSY;
            end else if (req_ch.step_count != 16'd0) begin
               running_in           = 1'b1;
               active_motor_in      = req_ch.motor_index;
               steps_left_in        = req_ch.step_count;
               phase_in             = 3'd0;
               reverse_in           = req_ch.direction[0];
               half_in              = req_ch.step_mode[0];
               hold_cnt_in          = 16'd0;
               rsp_in.drive_motor   = req_ch.motor_index;
               rsp_in.coil_pattern  = phase_pattern(req_ch.step_mode[0],
                                                    req_ch.direction[0], 3'd0);
               rsp_in.pattern_valid = 1'b1;
            end
         end
         FUNC_STOP: begin
            if (!idx_ok) begin
               rsp_in.status = STATUS_RANGE;
            end else begin
               rsp_in.drive_motor   = req_ch.motor_index;
               rsp_in.pattern_valid = 1'b1;
               // Abort the move only if it is on this motor
               if (running_ff && active_motor_ff == req_ch.motor_index) begin
                  running_in    = 1'b0;
                  steps_left_in = 16'd0;
                  hold_cnt_in   = 16'd0;
               end
            end
         end
         FUNC_TICK: begin
            if (running_ff) begin
               hold_cnt_in = cnt_inc;
               if (cnt_inc >= hold_eff) begin
                  hold_cnt_in = 16'd0;
                  if (phase_ff >= last_phase) begin
                     phase_in      = 3'd0;
                     steps_left_in = steps_dec;
                  end else begin
                     phase_in = phase_ff + 3'd1;
                  end
                  // Finish the move, keeping the last pattern on the coils
                  if (steps_left_in == 16'd0) begin
                     running_in       = 1'b0;
                     rsp_in.move_done = 1'b1;
                  end else begin
                     rsp_in.drive_motor   = active_motor_ff;
                     rsp_in.coil_pattern  = phase_pattern(half_ff, reverse_ff, phase_in);
                     rsp_in.pattern_valid = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.busy_res = running_in;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         active_motor_ff <= '0;
         steps_left_ff   <= '0;
         phase_ff        <= '0;
         reverse_ff      <= 1'b0;
         half_ff         <= 1'b0;
         hold_cnt_ff     <= '0;
         hold_ticks_ff   <= HOLD_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            running_ff      <= running_in;
            active_motor_ff <= active_motor_in;
            steps_left_ff   <= steps_left_in;
            phase_ff        <= phase_in;
            reverse_ff      <= reverse_in;
            half_ff         <= half_in;
            hold_cnt_ff     <= hold_cnt_in;
         end
         if (csr_ch.valid) begin
            hold_ticks_ff <= csr_ch.data;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the response channel
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.drive_motor   = rsp_ff.drive_motor;
   assign rsp_ch.coil_pattern  = rsp_ff.coil_pattern;
   assign rsp_ch.pattern_valid = rsp_ff.pattern_valid;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.busy_res      = rsp_ff.busy_res;
   assign rsp_ch.move_done     = rsp_ff.move_done;

endmodule
